// ----- rtl/frig_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frig_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the frame relative intensity gate.
// ----------------------------------------------------------------------------
package frig_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W   = 32;
    localparam int RAW_W     = 16;
    localparam int LEVEL_W   = 24;
    localparam int RATIO_W   = 16;
    localparam int GAIN_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RATIO     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_GAIN = 1'd1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd52429;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd100;

    typedef struct packed {
        logic store;
        logic thresh;
        logic read;
        logic load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rd_last;
    } t_status;

endpackage

// ----- rtl/frig_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frig_ctrl
// Sequencer: collects points while idle, then drains the stored frame
// one point per read/load pair.
// ----------------------------------------------------------------------------
module frig_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_stall,
    input  frig_pkg::t_status i_status,
    output frig_pkg::t_cmd    o_cmd
);
    import frig_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_THRESH,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_THRESH;
                end
            end
            S_THRESH: n_state = S_READ;
            S_READ:   n_state = S_LOAD;
            S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.rd_last ? S_IDLE : S_READ;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.store  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.thresh = (r_state == S_THRESH);
        o_cmd.read   = (r_state == S_READ);
        o_cmd.load   = (r_state == S_LOAD) && i_status.out_free;
        o_cmd.clear  = (r_state == S_LOAD) && i_status.out_free && i_status.rd_last;
    end

    assign o_in_stall = (r_state != S_IDLE);

    // drain runs only after the threshold product is formed
    a_thresh_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.thresh |=> o_cmd.read)
        else $error("read did not follow threshold");

    // a read is always followed by a load attempt
    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> (r_state == S_LOAD))
        else $error("load did not follow read");

    // no new point taken while a frame drains
    a_no_store_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.read || o_cmd.load || o_cmd.thresh) |-> !o_cmd.store)
        else $error("store during drain");

endmodule

// ----- rtl/frig_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frig_dp
// Datapath: config registers, point store, peak tracking, window test and
// output register.
// ----------------------------------------------------------------------------
module frig_dp #(
    parameter int MAX_POINTS = frig_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [frig_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [frig_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_x,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_y,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_z,
    input  logic [frig_pkg::RAW_W-1:0]           i_in_intensity,
    input  frig_pkg::t_cmd                       i_cmd,
    output frig_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_z,
    output logic [frig_pkg::LEVEL_W-1:0]         o_out_intensity,
    output logic                                 o_out_kept,
    output logic                                 o_out_last,
    output logic                                 o_out_overflow
);
    import frig_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = LEVEL_W + RATIO_W;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [LEVEL_W-1:0] level;
    } t_point;

    logic [RATIO_W-1:0] r_ratio;
    logic [GAIN_W-1:0]  r_gain;

    t_point             r_mem [MAX_POINTS];
    t_point             r_rd;
    logic               r_rd_last;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [LEVEL_W-1:0] r_peak;
    logic               r_dropped;
    logic [TW-1:0]      r_thresh;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [COORD_W-1:0] r_out_z;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_kept;
    logic               r_out_last;
    logic               r_out_overflow;

    logic [LEVEL_W-1:0] w_level;
    logic               w_room;
    logic               w_nonorigin;
    logic               w_keep;

    assign w_level     = {{(LEVEL_W-RAW_W){1'b0}}, i_in_intensity}
                       * {{(LEVEL_W-GAIN_W){1'b0}}, r_gain};
    assign w_room      = (r_count < CW'(MAX_POINTS));
    assign w_nonorigin = (i_in_x != '0) || (i_in_y != '0);
    assign w_keep      = ({r_rd.level, {RATIO_W{1'b0}}} > r_thresh) && (r_rd.level < r_peak);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEEP_RATIO:     r_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_INTENSITY_GAIN: r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_room) begin
            r_mem[r_count[AW-1:0]] <= '{x: i_in_x, y: i_in_y, z: i_in_z, level: w_level};
        end
        if (i_cmd.read) begin
            r_rd      <= r_mem[r_idx[AW-1:0]];
            r_rd_last <= (r_idx == (r_count - CW'(1)));
        end
        if (i_cmd.thresh) begin
            r_thresh <= {{RATIO_W{1'b0}}, r_peak} * {{LEVEL_W{1'b0}}, r_ratio};
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_peak    <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.store) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                    if (w_nonorigin && (w_level > r_peak)) begin
                        r_peak <= w_level;
                    end
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.thresh) begin
                r_idx <= '0;
            end else if (i_cmd.load) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_peak    <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_x        <= w_keep ? r_rd.x : '0;
            r_out_y        <= w_keep ? r_rd.y : '0;
            r_out_z        <= w_keep ? r_rd.z : '0;
            r_out_level    <= w_keep ? r_rd.level : '0;
            r_out_kept     <= w_keep;
            r_out_last     <= r_rd_last;
            r_out_overflow <= r_dropped;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.rd_last  = r_rd_last;

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_z         = r_out_z;
    assign o_out_intensity = r_out_level;
    assign o_out_kept      = r_out_kept;
    assign o_out_last      = r_out_last;
    assign o_out_overflow  = r_out_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten while stalled");

    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kept) |-> (r_out_level != '0))
        else $error("kept item with zero level");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kept) |->
            (r_out_x == '0 && r_out_y == '0 && r_out_z == '0 && r_out_level == '0))
        else $error("rejected item not zeroed");

endmodule

// ----- rtl/frame_relative_intensity_gate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_relative_intensity_gate
// Stores one frame of lidar points, tracks the peak scaled intensity and on
// the frame's last point emits every stored point through an intensity window.
// ----------------------------------------------------------------------------
// Collect: one point accepted per cycle; input stalls only while the threshold
// is formed or a frame drains. Drain: per result, a registered read of the
// point store, then a load of the output register, held while output stalls.
// Threshold product peak * keep_ratio is formed once per frame, before drain.
// Reset (synchronous, active low) clears the count, peak, overflow flag, the
// config registers to defaults and the output valid; point store is not cleared.
module frame_relative_intensity_gate #(
    parameter int MAX_POINTS = frig_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [frig_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [frig_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_x,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_y,
    input  logic signed [frig_pkg::COORD_W-1:0]  i_in_z,
    input  logic [frig_pkg::RAW_W-1:0]           i_in_intensity,
    input  logic                                 i_in_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [frig_pkg::COORD_W-1:0]  o_out_z,
    output logic [frig_pkg::LEVEL_W-1:0]         o_out_intensity,
    output logic                                 o_out_kept,
    output logic                                 o_out_last,
    output logic                                 o_out_overflow
);
    import frig_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    frig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    frig_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_x          (i_in_x),
        .i_in_y          (i_in_y),
        .i_in_z          (i_in_z),
        .i_in_intensity  (i_in_intensity),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_intensity (o_out_intensity),
        .o_out_kept      (o_out_kept),
        .o_out_last      (o_out_last),
        .o_out_overflow  (o_out_overflow)
    );

endmodule
